@@ src/rans_escape_symbol_encoder_defines.svh @@
// assertion macros shared by the checker
`ifndef RANS_ESCAPE_SYMBOL_ENCODER_DEFINES_SVH
`define RANS_ESCAPE_SYMBOL_ENCODER_DEFINES_SVH

// same-cycle implication
`define RESE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RESE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/rese_pkg.sv @@
package rese_pkg;

  localparam int ROWS_DEFAULT        = 64;
  localparam int CDF_DEPTH_DEFAULT   = 4096;
  localparam int MAX_ROW_LEN_DEFAULT = 64;

  localparam int PREC_BITS   = 16;
  localparam int BYPASS_BITS = 2;
  localparam int WORD_BITS   = 32;
  localparam logic [63:0] RANS_LOW = 64'h0000_0000_8000_0000;
  localparam logic [16:0] BYPASS_FREQ = 17'h04000;
  localparam logic [16:0] FREQ_MAX    = 17'h10000;

  localparam logic [1:0] KIND_LOAD_CDF = 2'd0;
  localparam logic [1:0] KIND_LOAD_ROW = 2'd1;
  localparam logic [1:0] KIND_ENCODE   = 2'd2;
  localparam logic [1:0] KIND_FLUSH    = 2'd3;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0_0000_0000_0001,
    S_ROW      = 13'b0_0000_0000_0010,
    S_NEXT     = 13'b0_0000_0000_0100,
    S_ADDR     = 13'b0_0000_0000_1000,
    S_RD0      = 13'b0_0000_0001_0000,
    S_RD1      = 13'b0_0000_0010_0000,
    S_RD2      = 13'b0_0000_0100_0000,
    S_RENORM   = 13'b0_0000_1000_0000,
    S_DIV      = 13'b0_0001_0000_0000,
    S_UPD      = 13'b0_0010_0000_0000,
    S_FIN      = 13'b0_0100_0000_0000,
    S_FLUSH_HI = 13'b0_1000_0000_0000,
    S_FLUSH_LO = 13'b1_0000_0000_0000
  } state_t;

  typedef enum logic [3:0] {
    PH_DIG   = 4'b0001,
    PH_CNT   = 4'b0010,
    PH_THREE = 4'b0100,
    PH_BIN   = 4'b1000
  } phase_t;

endpackage

@@ src/rans_escape_symbol_encoder.sv @@
// rANS encoder, 64-bit state, 16-bit precision, 32-bit words out. Items are
// taken one at a time. An encode looks up the row, then codes each slot: a
// bypass chunk goes through renormalization, a radix-16 divider and update; a
// cdf bin first wraps its address, makes two reads of the single cdf port,
// then renormalizes, divides and updates; an escaped symbol ends with the
// escape bin, and the item is then closed. A slot with a bad frequency is
// skipped. A flush pushes the two state words. Each word of an item is held
// one step back so the last one can carry tlast; output stalls stretch all this.
module rans_escape_symbol_encoder #(
  parameter int ROWS        = rese_pkg::ROWS_DEFAULT,
  parameter int CDF_DEPTH   = rese_pkg::CDF_DEPTH_DEFAULT,
  parameter int MAX_ROW_LEN = rese_pkg::MAX_ROW_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cdf_address[11:0] cdf_value[28:12] row[34:29] row_start[46:35]
  // row_length[53:47] row_offset[69:54] symbol_value[85:70]
  input  logic [87:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // word[31:0]
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  localparam int CW = $clog2(CDF_DEPTH);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  rese_pkg::state_t state;
  rese_pkg::phase_t phase;

  logic [16:0] cdf_mem [CDF_DEPTH];
  logic [16:0] cdf_rd;
  logic [34:0] row_mem [ROWS];
  logic [34:0] row_rd;

  logic [63:0] coder_state;
  logic [15:0] sym;
  logic [16:0] acc;
  logic [16:0] bin_addr;
  logic [16:0] cum;
  logic [16:0] freq;
  logic        slot_is_bin;
  logic [17:0] raw;
  logic [3:0]  dig_j;
  logic [1:0]  three_r;
  logic [1:0]  cnt_v;
  logic [63:0] dq;
  logic [17:0] rem;
  logic [3:0]  div_cnt;
  logic        h_valid;
  logic [31:0] h_word;

  logic        accept;
  logic [1:0]  kind_in;
  logic [11:0] cdf_addr_in;
  logic [5:0]  row_in;
  logic [6:0]  len_in;
  logic [6:0]  len_clamped;
  logic        out_free;
  logic        can_push;
  logic        push_en;
  logic [31:0] push_word;
  logic        fin_en;
  logic [CW-1:0] cdf_ra;
  logic [CW-1:0] acc_inc;

  logic [11:0] r_base;
  logic [6:0]  r_len;
  logic [15:0] r_off;
  logic [6:0]  len_eff;
  logic signed [16:0] idx;
  logic        in_range;
  logic [16:0] neg_mag;
  logic [16:0] pos_d;
  logic [17:0] raw_calc;
  logic [3:0]  n_chunks;
  logic [1:0]  n_div3;
  logic [1:0]  n_mod3;
  logic [1:0]  digit;
  logic        renorm;
  logic [17:0] rem_step;
  logic [63:0] dq_step;

  assign s_tready = (state == rese_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign kind_in  = s_tuser;
  assign cdf_addr_in = s_tdata[11:0];
  assign row_in   = s_tdata[34:29];
  assign len_in   = s_tdata[53:47];
  assign out_free = !m_tvalid || m_tready;
  assign can_push = !h_valid || out_free;

  always_comb begin
    len_clamped = len_in;
    if (len_in < 7'd2) begin
      len_clamped = 7'd2;
    end else if (int'(len_in) > MAX_ROW_LEN) begin
      len_clamped = 7'(MAX_ROW_LEN);
    end
  end

  // row descriptor memory
  always_ff @(posedge clk) begin
    if (accept && kind_in == rese_pkg::KIND_LOAD_ROW && int'(row_in) < ROWS) begin
      row_mem[RW'(row_in)] <= {s_tdata[69:54], len_clamped, s_tdata[46:35]};
    end
    row_rd <= row_mem[RW'(row_in)];
  end

  // cdf memory, one port for reads
  assign acc_inc = (acc[CW-1:0] == CW'(CDF_DEPTH - 1)) ? '0 : acc[CW-1:0] + 1'b1;
  assign cdf_ra  = (state == rese_pkg::S_RD1) ? acc_inc : acc[CW-1:0];

  always_ff @(posedge clk) begin
    if (accept && kind_in == rese_pkg::KIND_LOAD_CDF && int'(cdf_addr_in) < CDF_DEPTH) begin
      cdf_mem[CW'(cdf_addr_in)] <= s_tdata[28:12];
    end
    cdf_rd <= cdf_mem[cdf_ra];
  end

  // escape planning from the row descriptor
  always_comb begin
    r_base  = row_rd[11:0];
    r_len   = row_rd[18:12];
    r_off   = row_rd[34:19];
    len_eff = (r_len < 7'd2) ? 7'd2 : r_len;
    idx     = $signed({sym[15], sym}) + $signed({r_off[15], r_off});
    in_range = !idx[16] && (idx[15:0] <= 16'(len_eff) - 16'd2);
    neg_mag = 17'(-idx);
    pos_d   = 17'(idx) - 17'(len_eff) + 17'd1;
    raw_calc = idx[16] ? ({1'b0, neg_mag} << 1) - 18'd1 : {pos_d, 1'b0};
    n_chunks = '0;
    for (int i = 0; i < 9; i++) begin
      if (raw_calc[2*i +: 2] != 2'b00) begin
        n_chunks = 4'(i + 1);
      end
    end
    if (n_chunks >= 4'd9) begin
      n_div3 = 2'd3;
    end else if (n_chunks >= 4'd6) begin
      n_div3 = 2'd2;
    end else if (n_chunks >= 4'd3) begin
      n_div3 = 2'd1;
    end else begin
      n_div3 = 2'd0;
    end
    n_mod3 = 2'(n_chunks - {1'b0, n_div3, 1'b0} - {2'b0, n_div3});
  end

  assign digit  = 2'(raw >> {dig_j, 1'b0});
  assign renorm = (coder_state >= {freq, 47'b0});

  // four restoring steps per cycle
  always_comb begin
    rem_step = rem;
    dq_step  = dq;
    for (int i = 0; i < 4; i++) begin
      rem_step = {rem_step[16:0], dq_step[63]};
      dq_step  = {dq_step[62:0], 1'b0};
      if (rem_step >= {1'b0, freq}) begin
        rem_step   = rem_step - {1'b0, freq};
        dq_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    push_en   = 1'b0;
    push_word = coder_state[31:0];
    case (state)
      rese_pkg::S_RENORM: begin
        push_en = (freq != 17'd0) && (freq <= rese_pkg::FREQ_MAX) && renorm && can_push;
      end
      rese_pkg::S_FLUSH_HI: begin
        push_en   = can_push;
        push_word = coder_state[63:32];
      end
      rese_pkg::S_FLUSH_LO: begin
        push_en = can_push;
      end
      default: push_en = 1'b0;
    endcase
  end

  assign fin_en = (state == rese_pkg::S_FIN) && h_valid && out_free;

  // output register and one-word hold
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      h_valid  <= 1'b0;
    end else begin
      if ((push_en && h_valid) || fin_en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (push_en) begin
        h_valid <= 1'b1;
      end else if (fin_en) begin
        h_valid <= 1'b0;
      end
    end
    if (push_en) begin
      h_word <= push_word;
      if (h_valid) begin
        m_tdata <= h_word;
        m_tlast <= 1'b0;
      end
    end else if (fin_en) begin
      m_tdata <= h_word;
      m_tlast <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rese_pkg::S_IDLE;
      phase       <= rese_pkg::PH_BIN;
      coder_state <= rese_pkg::RANS_LOW;
    end else begin
      case (state)
        rese_pkg::S_IDLE: begin
          if (accept) begin
            sym <= s_tdata[85:70];
            if (kind_in == rese_pkg::KIND_ENCODE && int'(row_in) < ROWS) begin
              state <= rese_pkg::S_ROW;
            end else if (kind_in == rese_pkg::KIND_FLUSH) begin
              state <= rese_pkg::S_FLUSH_HI;
            end
          end
        end
        rese_pkg::S_ROW: begin
          bin_addr <= 17'(r_base) + 17'(len_eff) - 17'd1;
          if (in_range) begin
            acc         <= 17'(r_base) + 17'(idx[6:0]);
            slot_is_bin <= 1'b1;
            phase       <= rese_pkg::PH_BIN;
            state       <= rese_pkg::S_ADDR;
          end else begin
            raw     <= raw_calc;
            dig_j   <= n_chunks - 4'd1;
            three_r <= n_div3;
            cnt_v   <= n_mod3;
            phase   <= (n_chunks != 4'd0) ? rese_pkg::PH_DIG : rese_pkg::PH_CNT;
            state   <= rese_pkg::S_NEXT;
          end
        end
        rese_pkg::S_NEXT: begin
          if (phase == rese_pkg::PH_BIN) begin
            acc         <= bin_addr;
            slot_is_bin <= 1'b1;
            state       <= rese_pkg::S_ADDR;
          end else begin
            slot_is_bin <= 1'b0;
            freq        <= rese_pkg::BYPASS_FREQ;
            state       <= rese_pkg::S_RENORM;
            case (phase)
              rese_pkg::PH_DIG: begin
                cum <= {1'b0, digit, 14'b0};
                if (dig_j == 4'd0) begin
                  phase <= rese_pkg::PH_CNT;
                end
                dig_j <= dig_j - 4'd1;
              end
              rese_pkg::PH_CNT: begin
                cum   <= {1'b0, cnt_v, 14'b0};
                phase <= (three_r != 2'd0) ? rese_pkg::PH_THREE : rese_pkg::PH_BIN;
              end
              rese_pkg::PH_THREE: begin
                cum <= {3'b011, 14'b0};
                if (three_r == 2'd1) begin
                  phase <= rese_pkg::PH_BIN;
                end
                three_r <= three_r - 2'd1;
              end
              default: phase <= rese_pkg::PH_BIN;
            endcase
          end
        end
        rese_pkg::S_ADDR: begin
          // wrap modulo the cdf depth, one subtract a cycle
          if (acc >= 17'(CDF_DEPTH)) begin
            acc <= acc - 17'(CDF_DEPTH);
          end else begin
            state <= rese_pkg::S_RD0;
          end
        end
        rese_pkg::S_RD0: begin
          state <= rese_pkg::S_RD1;
        end
        rese_pkg::S_RD1: begin
          cum   <= cdf_rd;
          state <= rese_pkg::S_RD2;
        end
        rese_pkg::S_RD2: begin
          freq  <= cdf_rd - cum;
          state <= rese_pkg::S_RENORM;
        end
        rese_pkg::S_RENORM: begin
          rem     <= '0;
          div_cnt <= '0;
          if (freq == 17'd0 || freq > rese_pkg::FREQ_MAX) begin
            state <= slot_is_bin ? rese_pkg::S_FIN : rese_pkg::S_NEXT;
          end else if (!renorm) begin
            dq    <= coder_state;
            state <= rese_pkg::S_DIV;
          end else if (can_push) begin
            dq    <= {32'b0, coder_state[63:32]};
            state <= rese_pkg::S_DIV;
          end
        end
        rese_pkg::S_DIV: begin
          rem     <= rem_step;
          dq      <= dq_step;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            state <= rese_pkg::S_UPD;
          end
        end
        rese_pkg::S_UPD: begin
          coder_state <= {dq[47:0], 16'b0} + 64'(rem) + 64'(cum);
          state <= slot_is_bin ? rese_pkg::S_FIN : rese_pkg::S_NEXT;
        end
        rese_pkg::S_FLUSH_HI: begin
          if (can_push) begin
            state <= rese_pkg::S_FLUSH_LO;
          end
        end
        rese_pkg::S_FLUSH_LO: begin
          if (can_push) begin
            coder_state <= rese_pkg::RANS_LOW;
            state       <= rese_pkg::S_FIN;
          end
        end
        rese_pkg::S_FIN: begin
          if (!h_valid || out_free) begin
            state <= rese_pkg::S_IDLE;
          end
        end
        default: state <= rese_pkg::S_IDLE;
      endcase
    end
  end

endmodule

@@ src/rese_checker.sv @@
`include "rans_escape_symbol_encoder_defines.svh"

module rese_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  `RESE_ASSERT_NEXT(a_out_hold, !rst && m_tvalid && !m_tready, rst || (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
  `RESE_ASSERT_NEXT(a_reset_quiet, rst, !m_tvalid && s_tready)
  `RESE_ASSERT_NEXT(a_load_cdf_one_cycle, !rst && s_tvalid && s_tready && s_tuser == rese_pkg::KIND_LOAD_CDF, rst || s_tready)
  `RESE_ASSERT_NEXT(a_flush_busy, !rst && s_tvalid && s_tready && s_tuser == rese_pkg::KIND_FLUSH, !s_tready)
  `RESE_ASSERT_NOW(a_tlast_with_valid, !rst && m_tlast && m_tvalid, m_tvalid)

endmodule

bind rans_escape_symbol_encoder rese_checker u_rese_checker (.*);

@@ tb/rans_escape_symbol_encoder_tb.sv @@
`timescale 1ns / 1ps

module rans_escape_symbol_encoder_tb;
  import rese_pkg::*;

  localparam int SPAN_BASE = 4064;
  localparam int SPAN_LEN = 96;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [31:0] word;
    logic last;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0] s_tuser = KIND_FLUSH;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tlast;

  // predictor copy of the block state
  logic [63:0] coder_st;
  logic [16:0] cdf_mem [0:4095];
  bit cdf_written [0:4095];
  logic [11:0] row_base [0:63];
  logic [6:0] row_len [0:63];
  logic signed [15:0] row_off [0:63];
  bit row_loaded [0:63];

  word_t pending_words [$];
  logic [31:0] item_words [$];
  word_t got;
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  rans_escape_symbol_encoder u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rans_escape_symbol_encoder regression: fail");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // word checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report($sformatf("word %h with nothing expected", m_tdata));
      end else begin
        got = pending_words.pop_front();
        if (m_tdata !== got.word)
          report($sformatf("word %h, expected %h", m_tdata, got.word));
        if (m_tlast !== got.last)
          report($sformatf("last %b, expected %b", m_tlast, got.last));
      end
    end
  end

  // receiver back-pressure, one draw per transfer
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic code_slot(input logic [16:0] cum, input logic [16:0] freq);
    logic [63:0] f64;
    f64 = {47'd0, freq};
    if (freq == 17'd0 || freq > FREQ_MAX) return;
    if (coder_st >= 64'h0000_8000_0000_0000 * f64) begin
      item_words = {item_words, coder_st[31:0]};
      coder_st = coder_st >> WORD_BITS;
    end
    coder_st = ((coder_st / f64) << PREC_BITS) + (coder_st % f64) + {47'd0, cum};
  endtask

  task automatic code_bin(input logic [11:0] base, input int k);
    logic [16:0] c;
    logic [16:0] n;
    c = cdf_mem[(base + k) % 4096];
    n = cdf_mem[(base + k + 1) % 4096];
    code_slot(c, n - c);
  endtask

  task automatic code_bypass(input int unsigned v);
    code_slot(17'(v * BYPASS_FREQ), BYPASS_FREQ);
  endtask

  // expected words of one accepted item
  task automatic predict_words(input logic [1:0] kind, input logic [87:0] d);
    logic [5:0] r;
    int len;
    int maxd;
    int idx;
    int unsigned raw;
    int unsigned n;
    word_t w;
    r = d[34:29];
    item_words.delete();
    case (kind)
      KIND_LOAD_CDF: begin
        cdf_mem[d[11:0]] = d[28:12];
        cdf_written[d[11:0]] = 1'b1;
      end
      KIND_LOAD_ROW: begin
        len = int'(d[53:47]);
        if (len < 2) len = 2;
        if (len > 64) len = 64;
        row_base[r] = d[46:35];
        row_len[r] = 7'(len);
        row_off[r] = d[69:54];
        row_loaded[r] = 1'b1;
      end
      KIND_ENCODE: begin
        len = int'(row_len[r]);
        maxd = len - 2;
        idx = int'($signed(d[85:70])) + int'(row_off[r]);
        if (idx >= 0 && idx <= maxd) begin
          code_bin(row_base[r], idx);
        end else begin
          if (idx < 0) raw = (-idx) * 2 - 1;
          else raw = (idx - (maxd + 1)) * 2;
          n = 0;
          while (n < 16 && (raw >> (n * BYPASS_BITS)) != 0) n++;
          for (int j = int'(n) - 1; j >= 0; j--)
            code_bypass((raw >> (j * BYPASS_BITS)) & 3);
          code_bypass(n % 3);
          for (int unsigned t = n / 3; t > 0; t--) code_bypass(3);
          code_bin(row_base[r], len - 1);
        end
      end
      default: begin
        item_words = {item_words, coder_st[63:32]};
        item_words = {item_words, coder_st[31:0]};
        coder_st = RANS_LOW;
      end
    endcase
    foreach (item_words[i]) begin
      w.word = item_words[i];
      w.last = (i == item_words.size() - 1);
      pending_words = {pending_words, w};
    end
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [87:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    predict_words(kind, d);
  endtask

  // random filler in every field, then the used ones set
  function automatic logic [87:0] noise();
    return 88'({$urandom(), $urandom(), $urandom()});
  endfunction

  task automatic load_cdf(input int addr, input logic [16:0] val);
    logic [87:0] d;
    d = noise();
    d[11:0] = addr[11:0];
    d[28:12] = val;
    send_item(KIND_LOAD_CDF, d);
  endtask

  task automatic load_row(input int r, input int start, input int len_raw,
                          input logic [15:0] off);
    logic [87:0] d;
    d = noise();
    d[34:29] = r[5:0];
    d[46:35] = start[11:0];
    d[53:47] = len_raw[6:0];
    d[69:54] = off;
    send_item(KIND_LOAD_ROW, d);
  endtask

  task automatic encode(input int r, input logic [15:0] val);
    logic [87:0] d;
    d = noise();
    d[34:29] = r[5:0];
    d[85:70] = val;
    send_item(KIND_ENCODE, d);
  endtask

  task automatic flush();
    send_item(KIND_FLUSH, noise());
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic bit row_ready(input int r);
    if (!row_loaded[r]) return 1'b0;
    for (int k = 0; k <= row_len[r]; k++)
      if (!cdf_written[(row_base[r] + k) % 4096]) return 1'b0;
    return 1'b1;
  endfunction

  // monotone cdf over a span that wraps past the top address
  task automatic test_cdf_setup();
    int acc;
    acc = 0;
    for (int p = 0; p < SPAN_LEN; p++) begin
      load_cdf((SPAN_BASE + p) % 4096, 17'(acc));
      acc += $urandom_range(1, 680);
    end
  endtask

  task automatic test_directed();
    logic [16:0] c40;
    load_row(0, 4064, 127, 16'sd0);
    load_row(1, 0, 0, 16'sd0);
    load_row(2, 10, 1, 16'h7fff);
    load_row(3, 40, 5, 16'h8000);
    load_row(4, 40, 2, 16'sd0);
    encode(0, 16'sd0);
    encode(0, 16'sd62);
    encode(0, 16'sd63);
    encode(0, 16'hffff);
    encode(2, 16'h7fff);
    encode(3, 16'h8000);
    encode(1, 16'sd0);
    flush();
    flush();
    // zero frequency, then a wrapped one above full scale
    c40 = cdf_mem[40];
    load_cdf(41, c40);
    encode(4, 16'sd0);
    encode(3, 16'h8000);
    load_cdf(41, c40 - 17'd1);
    encode(4, 16'sd0);
    load_cdf(41, c40 + 17'd5);
    encode(4, 16'sd0);
    flush();
  endtask

  task automatic test_pause_until_empty();
    s_tvalid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    encode(0, 16'sd3);
    flush();
  endtask

  task automatic random_row_load();
    int r;
    int len_raw;
    int eff;
    int sel;
    logic [15:0] off;
    r = $urandom_range(0, 63);
    sel = $urandom_range(0, 19);
    if (sel == 0) len_raw = $urandom_range(0, 1);
    else if (sel == 1) len_raw = $urandom_range(65, 127);
    else len_raw = $urandom_range(2, 32);
    eff = len_raw < 2 ? 2 : (len_raw > 64 ? 64 : len_raw);
    off = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
    load_row(r, (SPAN_BASE + $urandom_range(0, SPAN_LEN - 1 - eff)) % 4096, len_raw, off);
  endtask

  task automatic random_encode();
    int r;
    logic [15:0] val;
    r = $urandom_range(0, 63);
    while (!row_ready(r)) r = (r + 1) % 64;
    val = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50) - 20);
    encode(r, val);
  endtask

  task automatic test_random(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      // bursts with no idling on either side
      if (i % 100 == 60) quiet = 1'b1;
      if (i % 100 == 80) quiet = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 3)
        load_cdf((SPAN_BASE + $urandom_range(0, SPAN_LEN - 1)) % 4096,
                 17'($urandom_range(0, 65536)));
      else if (sel < 8)
        load_cdf($urandom_range(0, 4095), 17'($urandom_range(0, 65536)));
      else if (sel < 18) random_row_load();
      else if (sel < 26) flush();
      else random_encode();
    end
    quiet = 1'b0;
  endtask

  initial begin
    coder_st = RANS_LOW;
    foreach (cdf_written[i]) cdf_written[i] = 1'b0;
    foreach (row_loaded[i]) row_loaded[i] = 1'b0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_cdf_setup();
    test_directed();
    test_pause_until_empty();
    for (int r = 5; r < 13; r++) random_row_load();
    test_random(290);
    s_tvalid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      report($sformatf("%0d expected words never came", pending_words.size()));
    if (errors == 0) begin
      $display("rans_escape_symbol_encoder regression: pass");
    end else begin
      $display("rans_escape_symbol_encoder regression: fail");
    end
    $finish;
  end

endmodule
